// ----- design/ggh_pkg.sv -----
package ggh_pkg;

  // Number of CORDIC micro-rotation cells in the chain (8 to 24).
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int STAGE_IDX_W   = $clog2(ATAN_ENTRIES);

  // Field widths.
  localparam int POS_W   = 16;
  localparam int ANGLE_W = 16;
  localparam int DIFF_W  = POS_W + 1;
  // Difference scaled by 256 plus headroom for the CORDIC gain.
  localparam int CORD_W  = 28;
  localparam int SQ_W    = 32;
  localparam int TOL_W   = 15;
  localparam int DTOL_W  = 16;
  localparam int SPEED_W = 15;
  localparam int MODE_W  = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_TOL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPD = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [TOL_W-1:0]   HEAD_TOL_RST  = 15'd2086;
  localparam logic [DTOL_W-1:0]  DIST_TOL_RST  = 16'd102;
  localparam logic [SPEED_W-1:0] TURN_RATE_RST = 15'd205;
  localparam logic [SPEED_W-1:0] DRIVE_SPD_RST = 15'd205;

  // Output modes.
  localparam logic [MODE_W-1:0] MODE_ROTATE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRANSLATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REACHED   = 2'd2;

  // Quarter turn in binary angle units.
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

  typedef struct packed {
    logic signed [CORD_W-1:0]  x;
    logic signed [CORD_W-1:0]  y;
    logic        [ANGLE_W-1:0] z;
  } cord_t;

  typedef struct packed {
    logic                       zero;
    logic                       near;
    logic signed [ANGLE_W-1:0]  heading;
  } tag_t;

  // Rounded atan(2^-i) in binary angle units (pi = 32768).
  function automatic logic [ANGLE_W-1:0] atan_lut(input logic [STAGE_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 16'd8192;
      5'd1:    v = 16'd4836;
      5'd2:    v = 16'd2555;
      5'd3:    v = 16'd1297;
      5'd4:    v = 16'd651;
      5'd5:    v = 16'd326;
      5'd6:    v = 16'd163;
      5'd7:    v = 16'd81;
      5'd8:    v = 16'd41;
      5'd9:    v = 16'd20;
      5'd10:   v = 16'd10;
      5'd11:   v = 16'd5;
      5'd12:   v = 16'd3;
      5'd13:   v = 16'd1;
      5'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/go_to_goal_heading_controller.sv -----
// Channel   Handshake               Payload
// input     start, busy             in_pos_x, in_pos_y, in_heading
// result    out_valid (strobe)      out_linear_cmd, out_angular_cmd, out_mode
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// A pose beat is taken on every clock edge with start high; busy is always low,
// so one pose per cycle. Each result passes through three front stages, one
// cell per CORDIC stage and one decision register.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the
// register defaults. The receiver cannot stall, so the pipeline never stops.
module go_to_goal_heading_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  // Pose input.
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ggh_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [ggh_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [ggh_pkg::ANGLE_W-1:0]  in_heading,
  // Command output.
  output logic                                out_valid,
  output logic [ggh_pkg::SPEED_W-1:0]         out_linear_cmd,
  output logic signed [ggh_pkg::ANGLE_W-1:0]  out_angular_cmd,
  output logic [ggh_pkg::MODE_W-1:0]          out_mode,
  // Register writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ggh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ggh_pkg::POS_W-1:0]           cfg_data
);

  // Configuration registers.
  logic signed [ggh_pkg::POS_W-1:0]  goal_x_r, goal_y_r;
  logic [ggh_pkg::TOL_W-1:0]         head_tol_r;
  logic [ggh_pkg::DTOL_W-1:0]        dist_tol_r;
  logic [ggh_pkg::SPEED_W-1:0]       turn_rate_r, drive_spd_r;
  // Squared distance tolerance, kept so the front end needs only one compare.
  logic [ggh_pkg::SQ_W-1:0]          tol_sq_r;
  logic                              cfg_we;

  // Chain wiring: entry k feeds cell k; the last entry feeds the decision.
  logic                              chain_valid [ggh_pkg::CORDIC_STAGES+1];
  ggh_pkg::cord_t                    chain_cord  [ggh_pkg::CORDIC_STAGES+1];
  ggh_pkg::tag_t                     chain_tag   [ggh_pkg::CORDIC_STAGES+1];

  // The pipeline never holds off a pose, and registers are written at once.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      head_tol_r  <= ggh_pkg::HEAD_TOL_RST;
      dist_tol_r  <= ggh_pkg::DIST_TOL_RST;
      turn_rate_r <= ggh_pkg::TURN_RATE_RST;
      drive_spd_r <= ggh_pkg::DRIVE_SPD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ggh_pkg::REG_GOAL_X:    goal_x_r    <= cfg_data;
        ggh_pkg::REG_GOAL_Y:    goal_y_r    <= cfg_data;
        ggh_pkg::REG_HEAD_TOL:  head_tol_r  <= cfg_data[ggh_pkg::TOL_W-1:0];
        ggh_pkg::REG_DIST_TOL:  dist_tol_r  <= cfg_data;
        ggh_pkg::REG_TURN_RATE: turn_rate_r <= cfg_data[ggh_pkg::SPEED_W-1:0];
        ggh_pkg::REG_DRIVE_SPD: drive_spd_r <= cfg_data[ggh_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // The square follows the tolerance in the next cycle; a pose reaches the
  // compare through the stage A and B registers, so the value is always settled.
  always_ff @(posedge clk) begin
    tol_sq_r <= dist_tol_r * dist_tol_r;
  end

  // Front end: goal-relative vector, pre-rotation into the right half plane,
  // and the squared-distance test against the tolerance.
  ggh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .heading   (in_heading),
    .goal_x    (goal_x_r),
    .goal_y    (goal_y_r),
    .tol_sq    (tol_sq_r),
    .out_valid (chain_valid[0]),
    .out_cord  (chain_cord[0]),
    .out_tag   (chain_tag[0])
  );

  // Row of vectoring cells; each applies one micro-rotation and passes the
  // pose tag alongside, so every pose moves one cell per cycle.
  for (genvar i = 0; i < ggh_pkg::CORDIC_STAGES; i++) begin : g_cell
    ggh_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (ggh_pkg::STAGE_IDX_W'(i)),
      .in_valid  (chain_valid[i]),
      .in_cord   (chain_cord[i]),
      .in_tag    (chain_tag[i]),
      .out_valid (chain_valid[i+1]),
      .out_cord  (chain_cord[i+1]),
      .out_tag   (chain_tag[i+1])
    );
  end

  // Heading error wrap and the rotate / drive / arrived choice.
  ggh_decide u_decide (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (chain_valid[ggh_pkg::CORDIC_STAGES]),
    .bearing_raw       (chain_cord[ggh_pkg::CORDIC_STAGES].z),
    .in_tag            (chain_tag[ggh_pkg::CORDIC_STAGES]),
    .heading_tolerance (head_tol_r),
    .turn_rate         (turn_rate_r),
    .drive_speed       (drive_spd_r),
    .out_valid         (out_valid),
    .linear_cmd        (out_linear_cmd),
    .angular_cmd       (out_angular_cmd),
    .mode              (out_mode)
  );

endmodule

// ----- design/ggh_front.sv -----
module ggh_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [ggh_pkg::POS_W-1:0]    pos_x,
  input  logic signed [ggh_pkg::POS_W-1:0]    pos_y,
  input  logic signed [ggh_pkg::ANGLE_W-1:0]  heading,
  input  logic signed [ggh_pkg::POS_W-1:0]    goal_x,
  input  logic signed [ggh_pkg::POS_W-1:0]    goal_y,
  input  logic        [ggh_pkg::SQ_W-1:0]     tol_sq,
  output logic                                out_valid,
  output ggh_pkg::cord_t                      out_cord,
  output ggh_pkg::tag_t                       out_tag
);

  // Stage A: differences and quarter-turn pre-rotation.
  logic                                   a_valid_r;
  logic signed [ggh_pkg::DIFF_W-1:0]      a_dx_r, a_dy_r;
  ggh_pkg::cord_t                         a_cord_r;
  ggh_pkg::tag_t                          a_tag_r;
  // Stage B: squared components.
  logic                                   b_valid_r;
  logic        [ggh_pkg::SQ_W-1:0]        b_sqx_r, b_sqy_r;
  ggh_pkg::cord_t                         b_cord_r;
  ggh_pkg::tag_t                          b_tag_r;
  // Stage C: distance compare.
  logic                                   c_valid_r;
  ggh_pkg::cord_t                         c_cord_r;
  ggh_pkg::tag_t                          c_tag_r;

  logic signed [ggh_pkg::DIFF_W-1:0]      dx, dy;
  logic signed [ggh_pkg::CORD_W-1:0]      xs, ys;
  ggh_pkg::cord_t                         a_cord_nxt;
  logic signed [2*ggh_pkg::DIFF_W-1:0]    prod_x, prod_y;
  logic        [ggh_pkg::SQ_W:0]          d2;

  always_comb begin
    dx = ggh_pkg::DIFF_W'(goal_x) - ggh_pkg::DIFF_W'(pos_x);
    dy = ggh_pkg::DIFF_W'(goal_y) - ggh_pkg::DIFF_W'(pos_y);
    xs = ggh_pkg::CORD_W'(dx) <<< 8;
    ys = ggh_pkg::CORD_W'(dy) <<< 8;
    a_cord_nxt.x = xs;
    a_cord_nxt.y = ys;
    a_cord_nxt.z = '0;
    if (dx < 0) begin
      if (dy >= 0) begin
        a_cord_nxt.x = ys;
        a_cord_nxt.y = -xs;
        a_cord_nxt.z = ggh_pkg::QUARTER_TURN;
      end else begin
        a_cord_nxt.x = -ys;
        a_cord_nxt.y = xs;
        a_cord_nxt.z = -ggh_pkg::QUARTER_TURN;
      end
    end
  end

  assign prod_x = a_dx_r * a_dx_r;
  assign prod_y = a_dy_r * a_dy_r;
  assign d2     = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_dx_r          <= dx;
    a_dy_r          <= dy;
    a_cord_r        <= a_cord_nxt;
    a_tag_r.zero    <= (dx == 0) && (dy == 0);
    a_tag_r.near    <= 1'b0;
    a_tag_r.heading <= heading;

    b_sqx_r  <= prod_x[ggh_pkg::SQ_W-1:0];
    b_sqy_r  <= prod_y[ggh_pkg::SQ_W-1:0];
    b_cord_r <= a_cord_r;
    b_tag_r  <= a_tag_r;

    c_cord_r         <= b_cord_r;
    c_tag_r.zero     <= b_tag_r.zero;
    c_tag_r.heading  <= b_tag_r.heading;
    c_tag_r.near     <= d2 < {1'b0, tol_sq};
  end

  assign out_valid = c_valid_r;
  assign out_cord  = c_cord_r;
  assign out_tag   = c_tag_r;

endmodule

// ----- design/ggh_cell.sv -----
module ggh_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ggh_pkg::STAGE_IDX_W-1:0]     stage_idx,
  input  logic                                in_valid,
  input  ggh_pkg::cord_t                      in_cord,
  input  ggh_pkg::tag_t                       in_tag,
  output logic                                out_valid,
  output ggh_pkg::cord_t                      out_cord,
  output ggh_pkg::tag_t                       out_tag
);

  logic                               valid_r;
  ggh_pkg::cord_t                     cord_r, cord_nxt;
  ggh_pkg::tag_t                      tag_r;
  logic signed [ggh_pkg::CORD_W-1:0]  x, y, xs, ys;
  logic        [ggh_pkg::ANGLE_W-1:0] step_angle;

  // One micro-rotation: drive y towards zero and track the angle turned.
  always_comb begin
    x          = in_cord.x;
    y          = in_cord.y;
    xs         = x >>> stage_idx;
    ys         = y >>> stage_idx;
    step_angle = ggh_pkg::atan_lut(stage_idx);
    if (y > 0) begin
      cord_nxt.x = x + ys;
      cord_nxt.y = y - xs;
      cord_nxt.z = in_cord.z + step_angle;
    end else begin
      cord_nxt.x = x - ys;
      cord_nxt.y = y + xs;
      cord_nxt.z = in_cord.z - step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cord_r <= cord_nxt;
    tag_r  <= in_tag;
  end

  assign out_valid = valid_r;
  assign out_cord  = cord_r;
  assign out_tag   = tag_r;

endmodule

// ----- design/ggh_decide.sv -----
module ggh_decide (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [ggh_pkg::ANGLE_W-1:0]         bearing_raw,
  input  ggh_pkg::tag_t                       in_tag,
  input  logic [ggh_pkg::TOL_W-1:0]           heading_tolerance,
  input  logic [ggh_pkg::SPEED_W-1:0]         turn_rate,
  input  logic [ggh_pkg::SPEED_W-1:0]         drive_speed,
  output logic                                out_valid,
  output logic [ggh_pkg::SPEED_W-1:0]         linear_cmd,
  output logic signed [ggh_pkg::ANGLE_W-1:0]  angular_cmd,
  output logic [ggh_pkg::MODE_W-1:0]          mode
);

  logic                               valid_r;
  logic [ggh_pkg::SPEED_W-1:0]        lin_r, lin_nxt;
  logic signed [ggh_pkg::ANGLE_W-1:0] ang_r, ang_nxt;
  logic [ggh_pkg::MODE_W-1:0]         mode_r, mode_nxt;
  logic [ggh_pkg::ANGLE_W-1:0]        bearing, err, mag;

  always_comb begin
    // A robot sitting on the goal point has a bearing of zero.
    bearing = in_tag.zero ? '0 : bearing_raw;
    err     = bearing - in_tag.heading;
    // Magnitude of a half turn comes out as 32768, above any tolerance.
    mag     = err[ggh_pkg::ANGLE_W-1] ? (~err + 1'b1) : err;
    if (mag > {1'b0, heading_tolerance}) begin
      lin_nxt  = '0;
      ang_nxt  = err[ggh_pkg::ANGLE_W-1] ? -ggh_pkg::ANGLE_W'(turn_rate)
                                         : ggh_pkg::ANGLE_W'(turn_rate);
      mode_nxt = ggh_pkg::MODE_ROTATE;
    end else if (!in_tag.near) begin
      lin_nxt  = drive_speed;
      ang_nxt  = '0;
      mode_nxt = ggh_pkg::MODE_TRANSLATE;
    end else begin
      lin_nxt  = '0;
      ang_nxt  = '0;
      mode_nxt = ggh_pkg::MODE_REACHED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lin_r  <= lin_nxt;
    ang_r  <= ang_nxt;
    mode_r <= mode_nxt;
  end

  assign out_valid   = valid_r;
  assign linear_cmd  = lin_r;
  assign angular_cmd = ang_r;
  assign mode        = mode_r;

endmodule

// ----- verif/go_to_goal_heading_controller_test.sv -----
`timescale 1ns / 1ps

module go_to_goal_heading_controller_test;

  // Pipeline depth from pose beat to command beat, as given for the block.
  localparam int LATENCY = ggh_pkg::CORDIC_STAGES + 4;
  // Generous bound on the whole run; the slowest correct run needs far fewer cycles.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int POSES_PER_PHASE = 315;

  // The index field has room for two registers that do not exist.
  localparam logic [ggh_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [ggh_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic        [ggh_pkg::SPEED_W-1:0] linear;
    logic signed [ggh_pkg::ANGLE_W-1:0] angular;
    logic        [ggh_pkg::MODE_W-1:0]  mode;
  } command_t;

  // One line of the directed script: either a register write or a pose beat,
  // the latter with an optional hand-written command.
  typedef struct {
    bit                                 is_write;
    logic [ggh_pkg::CFG_IDX_W-1:0]      index;
    logic [ggh_pkg::POS_W-1:0]          data;
    logic signed [ggh_pkg::POS_W-1:0]   px;
    logic signed [ggh_pkg::POS_W-1:0]   py;
    logic signed [ggh_pkg::ANGLE_W-1:0] hd;
    bit                                 typed;
    command_t                           cmd;
  } script_row_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic signed [ggh_pkg::POS_W-1:0]    in_pos_x;
  logic signed [ggh_pkg::POS_W-1:0]    in_pos_y;
  logic signed [ggh_pkg::ANGLE_W-1:0]  in_heading;
  logic                                out_valid;
  logic [ggh_pkg::SPEED_W-1:0]         out_linear_cmd;
  logic signed [ggh_pkg::ANGLE_W-1:0]  out_angular_cmd;
  logic [ggh_pkg::MODE_W-1:0]          out_mode;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [ggh_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [ggh_pkg::POS_W-1:0]           cfg_data;

  // Shadow copy of the register file, updated when a write beat is taken.
  logic signed [ggh_pkg::POS_W-1:0]    goal_x_q;
  logic signed [ggh_pkg::POS_W-1:0]    goal_y_q;
  logic [ggh_pkg::TOL_W-1:0]           head_tol_q;
  logic [ggh_pkg::DTOL_W-1:0]          dist_tol_q;
  logic [ggh_pkg::SPEED_W-1:0]         turn_rate_q;
  logic [ggh_pkg::SPEED_W-1:0]         drive_spd_q;

  // Commands still owed by the block, oldest first.
  command_t    pending_cmds[$];
  script_row_t script_q[$];
  command_t    want_cmd;
  int          mismatches = 0;
  int          cycles = 0;

  // Rounded arctangent of 2^-i in binary angle units.
  int atan_rom [ggh_pkg::ATAN_ENTRIES] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                           41, 20, 10, 5, 3, 1, 1, 0,
                                           0, 0, 0, 0, 0, 0, 0, 0};

  go_to_goal_heading_controller u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_heading      (in_heading),
    .out_valid       (out_valid),
    .out_linear_cmd  (out_linear_cmd),
    .out_angular_cmd (out_angular_cmd),
    .out_mode        (out_mode),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bearing of the vector (dx, dy) by vectoring CORDIC. The vector is scaled
  // by 256 first; a vector in the left half plane is turned by a quarter turn
  // so that the micro-rotations only have to cover the right half. The shifts
  // are arithmetic and round towards minus infinity. A zero vector has
  // bearing zero.
  function automatic logic signed [ggh_pkg::ANGLE_W-1:0] cordic_bearing(input int dx,
                                                                        input int dy);
    longint x;
    longint y;
    longint t;
    longint xs;
    longint ys;
    int     z;
    z = 0;
    if (dx == 0 && dy == 0) begin
      return '0;
    end
    x = longint'(dx) * 256;
    y = longint'(dy) * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = int'(ggh_pkg::QUARTER_TURN);
      end else begin
        x = -y;
        y = t;
        z = -int'(ggh_pkg::QUARTER_TURN);
      end
    end
    for (int i = 0; i < ggh_pkg::CORDIC_STAGES && i < ggh_pkg::ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_rom[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_rom[i];
      end
    end
    return z[ggh_pkg::ANGLE_W-1:0];
  endfunction

  // Bang-bang decision for one pose under the current shadow registers.
  function automatic command_t predict_command(
      input logic signed [ggh_pkg::POS_W-1:0]   px,
      input logic signed [ggh_pkg::POS_W-1:0]   py,
      input logic signed [ggh_pkg::ANGLE_W-1:0] hd);
    int                                 dx;
    int                                 dy;
    logic signed [ggh_pkg::ANGLE_W-1:0] err;
    int                                 mag;
    longint                             d2;
    longint                             t2;
    command_t                           c;
    dx = int'(goal_x_q) - int'(px);
    dy = int'(goal_y_q) - int'(py);
    // The subtraction wraps to 16 bits, so an error of pi comes out as -32768.
    err = cordic_bearing(dx, dy) - hd;
    mag = (err < 0) ? -int'(err) : int'(err);
    d2 = longint'(dx) * dx + longint'(dy) * dy;
    t2 = longint'(dist_tol_q) * longint'(dist_tol_q);
    c = '0;
    if (mag > int'(head_tol_q)) begin
      c.angular = (err < 0) ? -$signed({1'b0, turn_rate_q}) : $signed({1'b0, turn_rate_q});
      c.mode = ggh_pkg::MODE_ROTATE;
    end else if (d2 >= t2) begin
      c.linear = drive_spd_q;
      c.mode = ggh_pkg::MODE_TRANSLATE;
    end else begin
      c.mode = ggh_pkg::MODE_REACHED;
    end
    return c;
  endfunction

  function automatic void apply_write(input logic [ggh_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [ggh_pkg::POS_W-1:0] data);
    case (idx)
      ggh_pkg::REG_GOAL_X:    goal_x_q = data;
      ggh_pkg::REG_GOAL_Y:    goal_y_q = data;
      ggh_pkg::REG_HEAD_TOL:  head_tol_q = data[ggh_pkg::TOL_W-1:0];
      ggh_pkg::REG_DIST_TOL:  dist_tol_q = data;
      ggh_pkg::REG_TURN_RATE: turn_rate_q = data[ggh_pkg::SPEED_W-1:0];
      ggh_pkg::REG_DRIVE_SPD: drive_spd_q = data[ggh_pkg::SPEED_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic command_t make_cmd(input logic [ggh_pkg::SPEED_W-1:0] lin,
                                        input logic signed [ggh_pkg::ANGLE_W-1:0] ang,
                                        input logic [ggh_pkg::MODE_W-1:0] md);
    command_t c;
    c.linear = lin;
    c.angular = ang;
    c.mode = md;
    return c;
  endfunction

  function automatic void add_pose(input logic signed [ggh_pkg::POS_W-1:0] px,
                                   input logic signed [ggh_pkg::POS_W-1:0] py,
                                   input logic signed [ggh_pkg::ANGLE_W-1:0] hd);
    script_q.push_back('{1'b0, '0, '0, px, py, hd, 1'b0, '0});
  endfunction

  function automatic void add_typed(input logic signed [ggh_pkg::POS_W-1:0] px,
                                    input logic signed [ggh_pkg::POS_W-1:0] py,
                                    input logic signed [ggh_pkg::ANGLE_W-1:0] hd,
                                    input command_t c);
    script_q.push_back('{1'b0, '0, '0, px, py, hd, 1'b1, c});
  endfunction

  function automatic void add_write(input logic [ggh_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [ggh_pkg::POS_W-1:0] data);
    script_q.push_back('{1'b1, idx, data, '0, '0, '0, 1'b0, '0});
  endfunction

  // Present one pose beat at the falling edge and hold it until a rising edge
  // finds busy low. The expected command is booked at that edge, so it is
  // worked out with the registers that the block itself is using.
  task automatic send_pose(input logic signed [ggh_pkg::POS_W-1:0] px,
                           input logic signed [ggh_pkg::POS_W-1:0] py,
                           input logic signed [ggh_pkg::ANGLE_W-1:0] hd,
                           input bit typed,
                           input command_t c);
    @(negedge clk);
    start <= 1'b1;
    cfg_valid <= 1'b0;
    in_pos_x <= px;
    in_pos_y <= py;
    in_heading <= hd;
    do @(posedge clk); while (busy);
    pending_cmds.push_back(typed ? c : predict_command(px, py, hd));
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Register writes are only made with the pipeline empty. Every pose yields
  // a command, so an empty queue means the pipeline has run dry.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // A write beat is held until the block shows ready; valid is left high so
  // that back-to-back writes need not drop it in between.
  task automatic write_reg(input logic [ggh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ggh_pkg::POS_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_write(idx, data);
  endtask

  // Every command beat is checked against the oldest booked command. The
  // receiver cannot hold the block off, so a strobe is taken at face value.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected command beat: linear %0d angular %0d mode %0d",
                   out_linear_cmd, out_angular_cmd, out_mode);
        end
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (out_linear_cmd !== want_cmd.linear || out_angular_cmd !== want_cmd.angular ||
            out_mode !== want_cmd.mode) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want lin %0d ang %0d mode %0d, got lin %0d ang %0d mode %0d",
                     want_cmd.linear, want_cmd.angular, want_cmd.mode,
                     out_linear_cmd, out_angular_cmd, out_mode);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("go_to_goal_heading_controller verification failed");
      $finish;
    end
  end

  initial begin
    int                                 idle_pct [RANDOM_PHASES];
    logic signed [ggh_pkg::POS_W-1:0]   px;
    logic signed [ggh_pkg::POS_W-1:0]   py;
    logic signed [ggh_pkg::ANGLE_W-1:0] hd;
    logic signed [ggh_pkg::ANGLE_W-1:0] brg;
    logic [ggh_pkg::POS_W-1:0]          gx;
    logic [ggh_pkg::POS_W-1:0]          gy;
    logic [ggh_pkg::POS_W-1:0]          htol;
    logic [ggh_pkg::POS_W-1:0]          dtol;
    logic [ggh_pkg::POS_W-1:0]          trate;
    logic [ggh_pkg::POS_W-1:0]          dspd;
    int                                 k;
    int                                 r;
    int                                 off;
    int                                 burst_left;
    bit                                 prev_write;
    script_row_t                        row;

    // Every input is known from time zero; reset is held low at the start and released at a falling edge.
    rst_n = 1'b0;
    start = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_heading = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    goal_x_q = '0;
    goal_y_q = '0;
    head_tol_q = ggh_pkg::HEAD_TOL_RST;
    dist_tol_q = ggh_pkg::DIST_TOL_RST;
    turn_rate_q = ggh_pkg::TURN_RATE_RST;
    drive_spd_q = ggh_pkg::DRIVE_SPD_RST;

    // The sender's share of idle cycles in each random phase. The receiver
    // cannot stall this block, so those profiles reduce to sender gaps alone.
    idle_pct = '{0, 63, 0, 29, 63, 29};

    // Directed script, first with the reset values: goal at the origin,
    // heading tolerance 2086, distance tolerance 102, both speeds 205.
    // The robot standing on the goal has bearing zero, so the heading alone
    // decides, and an error of exactly pi turns clockwise.
    add_typed(16'sd0, 16'sd0, 16'sd0, make_cmd('0, '0, ggh_pkg::MODE_REACHED));
    add_typed(16'sd0, 16'sd0, -16'sd32768, make_cmd('0, -16'sd205, ggh_pkg::MODE_ROTATE));
    add_typed(16'sd0, 16'sd0, 16'sd16384, make_cmd('0, -16'sd205, ggh_pkg::MODE_ROTATE));
    add_typed(16'sd0, 16'sd0, -16'sd16384, make_cmd('0, 16'sd205, ggh_pkg::MODE_ROTATE));
    // Heading error exactly on the tolerance does not turn; one more does.
    add_typed(16'sd0, 16'sd0, 16'sd2086, make_cmd('0, '0, ggh_pkg::MODE_REACHED));
    add_typed(16'sd0, 16'sd0, 16'sd2087, make_cmd('0, -16'sd205, ggh_pkg::MODE_ROTATE));
    // Position extremes give the widest differences.
    add_pose(-16'sd32768, 16'sd0, 16'sd0);
    add_pose(16'sd32767, 16'sd0, -16'sd32768);
    add_pose(16'sd0, -16'sd32768, 16'sd16384);
    add_pose(16'sd0, 16'sd32767, -16'sd16384);
    add_pose(-16'sd32768, -16'sd32768, 16'sd8192);
    add_pose(16'sd32767, 16'sd32767, -16'sd24576);
    add_pose(16'sd32767, 16'sd32767, 16'sd32767);
    // Distance exactly on the tolerance still drives; one less is arrival.
    add_typed(-16'sd102, 16'sd0, 16'sd0, make_cmd(15'd205, '0, ggh_pkg::MODE_TRANSLATE));
    add_typed(-16'sd101, 16'sd0, 16'sd0, make_cmd('0, '0, ggh_pkg::MODE_REACHED));
    // With a zero distance tolerance, standing on the goal still drives.
    add_write(ggh_pkg::REG_DIST_TOL, 16'd0);
    add_typed(16'sd0, 16'sd0, 16'sd0, make_cmd(15'd205, '0, ggh_pkg::MODE_TRANSLATE));
    // The widest tolerance still cannot swallow an error of pi.
    add_write(ggh_pkg::REG_HEAD_TOL, 16'd32767);
    add_write(ggh_pkg::REG_TURN_RATE, 16'd32767);
    add_write(ggh_pkg::REG_DRIVE_SPD, 16'd32767);
    add_typed(16'sd0, 16'sd0, -16'sd32768,
              make_cmd('0, -16'sd32767, ggh_pkg::MODE_ROTATE));
    add_typed(16'sd0, 16'sd0, 16'sd1, make_cmd(15'd32767, '0, ggh_pkg::MODE_TRANSLATE));
    // Goal at the corner of the field, tightest heading, widest distance.
    add_write(ggh_pkg::REG_GOAL_X, 16'h7fff);
    add_write(ggh_pkg::REG_GOAL_Y, 16'h8000);
    add_write(ggh_pkg::REG_HEAD_TOL, 16'd0);
    add_write(ggh_pkg::REG_DIST_TOL, 16'hffff);
    add_write(ggh_pkg::REG_TURN_RATE, 16'd0);
    add_write(ggh_pkg::REG_DRIVE_SPD, 16'd0);
    add_pose(-16'sd32768, 16'sd32767, 16'sd0);
    add_typed(16'sd32767, -16'sd32768, 16'sd0, make_cmd('0, '0, ggh_pkg::MODE_REACHED));
    // Writes to indexes beyond the register file must change nothing.
    add_write(REG_SPARE_A, 16'h1234);
    add_write(REG_SPARE_B, 16'hffff);
    add_typed(16'sd32767, -16'sd32768, 16'sd0, make_cmd('0, '0, ggh_pkg::MODE_REACHED));
    add_typed(16'sd32767, -16'sd32768, 16'sd1, make_cmd('0, '0, ggh_pkg::MODE_ROTATE));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    prev_write = 1'b1;
    foreach (script_q[i]) begin
      row = script_q[i];
      if (row.is_write) begin
        if (!prev_write) begin
          drain_results();
        end
        write_reg(row.index, row.data);
      end else begin
        send_pose(row.px, row.py, row.hd, row.typed, row.cmd);
      end
      prev_write = row.is_write;
    end

    // Random phases, each under its own register setting, counted from zero. Phase one
    // puts the tolerances and speeds at their maximum, phase two at their minimum,
    // phase four puts the goal on the corners; the rest are drawn at random.
    burst_left = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      gx = ggh_pkg::POS_W'($urandom_range(0, 65535));
      gy = ggh_pkg::POS_W'($urandom_range(0, 65535));
      htol = ggh_pkg::POS_W'($urandom_range(0, 1) ? $urandom_range(0, 4000)
                                                   : $urandom_range(0, 65535));
      dtol = ggh_pkg::POS_W'($urandom_range(0, 1) ? $urandom_range(0, 1500)
                                                   : $urandom_range(0, 65535));
      trate = ggh_pkg::POS_W'($urandom_range(0, 65535));
      dspd = ggh_pkg::POS_W'($urandom_range(0, 65535));
      if (p == 1) begin
        htol = 16'd32767;
        dtol = 16'hffff;
        trate = 16'd32767;
        dspd = 16'd32767;
      end else if (p == 2) begin
        htol = '0;
        dtol = '0;
        trate = '0;
        dspd = '0;
      end else if (p == 4) begin
        gx = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        gy = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      end
      write_reg(ggh_pkg::REG_GOAL_X, gx);
      write_reg(ggh_pkg::REG_GOAL_Y, gy);
      write_reg(ggh_pkg::REG_HEAD_TOL, htol);
      write_reg(ggh_pkg::REG_DIST_TOL, dtol);
      write_reg(ggh_pkg::REG_TURN_RATE, trate);
      write_reg(ggh_pkg::REG_DRIVE_SPD, dspd);
      if (p == 3) begin
        write_reg(REG_SPARE_A, ggh_pkg::POS_W'($urandom_range(0, 65535)));
        write_reg(REG_SPARE_B, ggh_pkg::POS_W'($urandom_range(0, 65535)));
      end

      for (int n = 0; n < POSES_PER_PHASE; n++) begin
        // Occasional bursts with no gaps at all, whatever the phase.
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 99) < 3) begin
          burst_left = $urandom_range(8, 40);
        end
        while (burst_left == 0 && $urandom_range(0, 99) < idle_pct[p]) begin
          idle_cycle();
        end

        // Most poses sit near the goal or face close to it, so that every
        // decision is taken often; the remainder is unshaped noise.
        k = $urandom_range(0, 99);
        if (k < 35) begin
          r = int'(dist_tol_q) + 3;
          if (r > 3000) r = 3000;
          px = ggh_pkg::POS_W'(int'(goal_x_q) - (int'($urandom_range(0, 2 * r)) - r));
          py = ggh_pkg::POS_W'(int'(goal_y_q) - (int'($urandom_range(0, 2 * r)) - r));
        end else if (k < 45) begin
          px = goal_x_q;
          py = goal_y_q;
        end else if (k < 50) begin
          // Exactly on the distance tolerance along one axis.
          px = ggh_pkg::POS_W'(int'(goal_x_q) - int'(dist_tol_q));
          py = goal_y_q;
        end else begin
          px = ggh_pkg::POS_W'($urandom_range(0, 65535));
          py = ggh_pkg::POS_W'($urandom_range(0, 65535));
        end

        if ($urandom_range(0, 99) < 75) begin
          brg = cordic_bearing(int'(goal_x_q) - int'(px), int'(goal_y_q) - int'(py));
          if ($urandom_range(0, 9) == 0) begin
            off = int'(head_tol_q) + int'($urandom_range(0, 1));
          end else begin
            r = int'(head_tol_q) + 2;
            off = int'($urandom_range(0, 2 * r)) - r;
          end
          if ($urandom_range(0, 1)) off = -off;
          hd = ggh_pkg::ANGLE_W'(int'(brg) + off);
        end else begin
          hd = ggh_pkg::ANGLE_W'($urandom_range(0, 65535));
        end
        send_pose(px, py, hd, 1'b0, '0);
      end
    end

    // Let the pipeline run dry, then keep watching the output for any stray
    // command beat to show itself.
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);

    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("go_to_goal_heading_controller verification clean");
    end else begin
      $display("go_to_goal_heading_controller verification failed");
    end
    $finish;
  end

endmodule
